// ----- hw/rtl/msb_pkg.sv -----
// msb_pkg: shared types for the merge sort block.
// Payload structs, controller state encoding, command and status bundles.
// No dependencies.
package msb_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_out;
    logic               overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_PASS_START,
    S_RUN_START,
    S_RUN_RD2,
    S_MERGE,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic in_ready;
    logic load;
    logic sort_init;
    logic pass_init;
    logic run_init;
    logic run_rd2;
    logic merge;
    logic pass_done;
    logic emit_init;
    logic emit_rd;
    logic emit_ld;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic width_lt_n;
    logic run_last;
    logic pass_last;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

// ----- hw/rtl/msb_stream_if.sv -----
// msb_stream_if: valid/ready channel carrying one request payload.
// Payload type is set per instance; depends on nothing.
interface msb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/merge_sort_block_unit.sv -----
// merge_sort_block_unit: batch sorter for signed 32-bit values.
// Loading: one request per cycle while collecting. After the request marked last (n stored
// values) the sort runs P = ceil(log2 n) merge passes, each reading through the single
// read port of the buffer in use; emit then reads and registers one result at a time.
// Synchronous active-high reset clears count, drop flag, sequencer and output valid.
module merge_sort_block_unit #(
  parameter int MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst,
  msb_stream_if.sink   item,
  msb_stream_if.source result
);
  msb_pkg::cmd_t    cmd;
  msb_pkg::status_t status;
  logic             out_valid;
  msb_pkg::out_item_t out_data;

  // Input requests are taken only while collecting; a request beyond
  // capacity is accepted and dropped, and its last mark still ends the batch.
  assign item.ready = cmd.in_ready;

  // Controller: collect -> merge passes (ping-pong between store and
  // scratch, run width doubling) -> emit in ascending order.
  msb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .last_in    (item.payload.last_in),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath: two buffers, merge pointers with head registers so one
  // element is merged per cycle within a run, and the result register.
  msb_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item_data (item.payload),
    .out_ready (result.ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

  // Result register holds while the sink stalls; the next batch can load
  // as soon as the final result is in it.
  assign result.valid   = out_valid;
  assign result.payload = out_data;
endmodule

// ----- hw/rtl/msb_ram.sv -----
// msb_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
module msb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- hw/rtl/msb_ctrl.sv -----
// msb_ctrl: sequencer for collect, bottom-up merge passes and emit.
// Uses msb_pkg state, command and status types.
module msb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              last_in,
  input  msb_pkg::status_t  status,
  output msb_pkg::cmd_t     cmd
);
  msb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msb_pkg::S_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      msb_pkg::S_COLLECT: begin
        cmd.in_ready = 1'b1;
        if (item_valid) begin
          cmd.load = 1'b1;
          if (last_in) begin
            cmd.sort_init = 1'b1;
            state_next    = msb_pkg::S_PASS_START;
          end
        end
      end
      msb_pkg::S_PASS_START: begin
        if (status.width_lt_n) begin
          cmd.pass_init = 1'b1;
          state_next    = msb_pkg::S_RUN_START;
        end else begin
          cmd.emit_init = 1'b1;
          state_next    = msb_pkg::S_EMIT_RD;
        end
      end
      msb_pkg::S_RUN_START: begin
        cmd.run_init = 1'b1;
        state_next   = msb_pkg::S_RUN_RD2;
      end
      msb_pkg::S_RUN_RD2: begin
        cmd.run_rd2 = 1'b1;
        state_next  = msb_pkg::S_MERGE;
      end
      msb_pkg::S_MERGE: begin
        cmd.merge = 1'b1;
        if (status.run_last) begin
          if (status.pass_last) begin
            cmd.pass_done = 1'b1;
            state_next    = msb_pkg::S_PASS_START;
          end else begin
            state_next = msb_pkg::S_RUN_START;
          end
        end
      end
      msb_pkg::S_EMIT_RD: begin
        if (status.out_free) begin
          cmd.emit_rd = 1'b1;
          state_next  = msb_pkg::S_EMIT_LD;
        end
      end
      msb_pkg::S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        if (status.emit_last) begin
          state_next = msb_pkg::S_COLLECT;
        end else begin
          state_next = msb_pkg::S_EMIT_RD;
        end
      end
      default: begin
        state_next = msb_pkg::S_COLLECT;
      end
    endcase
  end
endmodule

// ----- hw/rtl/msb_datapath.sv -----
// msb_datapath: element store, scratch buffer, merge pointers and output register.
// Uses msb_pkg types and two msb_ram instances.
module msb_datapath #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  msb_pkg::cmd_t       cmd,
  input  msb_pkg::in_item_t   item_data,
  input  logic                out_ready,
  output logic                out_valid,
  output msb_pkg::out_item_t  out_data,
  output msb_pkg::status_t    status
);
  localparam int CW = $clog2(MAX_ITEMS + 1);  // counts and indexes 0..MAX_ITEMS
  localparam int AW = $clog2(MAX_ITEMS);      // buffer address
  localparam int SW = CW + 2;                 // run bound sums

  // control state
  logic [CW-1:0] count;
  logic          dropped;

  // merge state
  logic [CW:0]   width;
  logic          src_sel;  // 0: sorted data in store A, 1: in scratch B
  logic [CW-1:0] lo, mid, hi, i, j, k;
  logic signed [31:0] head_a, head_b;
  logic          took_a, took_b;

  // RAM ports
  logic          a_we, b_we, rd_en;
  logic [AW-1:0] a_waddr, raddr;
  logic [31:0]   a_wdata, a_rdata, b_rdata, rdata;

  logic [SW-1:0] mid_sum, hi_sum, n_ext;
  logic [CW-1:0] mid_c, hi_c, i_inc, j_inc, k_inc;
  logic          full, a_avail, b_avail, take_a;
  logic signed [31:0] a_eff, b_eff, merge_val;

  assign full    = (count == CW'(MAX_ITEMS));
  assign n_ext   = SW'(count);
  assign mid_sum = SW'(lo) + SW'(width);
  assign hi_sum  = SW'(lo) + (SW'(width) << 1);
  assign mid_c   = (mid_sum > n_ext) ? count : mid_sum[CW-1:0];
  assign hi_c    = (hi_sum > n_ext) ? count : hi_sum[CW-1:0];
  assign i_inc   = i + 1'b1;
  assign j_inc   = j + 1'b1;
  assign k_inc   = k + 1'b1;

  assign rdata = src_sel ? b_rdata : a_rdata;

  // heads: the side consumed last cycle arrives fresh from the RAM
  assign a_eff   = took_a ? $signed(rdata) : head_a;
  assign b_eff   = took_b ? $signed(rdata) : head_b;
  assign a_avail = (i < mid);
  assign b_avail = (j < hi);
  assign take_a  = a_avail && (!b_avail || (a_eff <= b_eff));
  assign merge_val = take_a ? a_eff : b_eff;

  assign status.width_lt_n = (SW'(width) < n_ext);
  assign status.run_last   = (k_inc == hi);
  assign status.pass_last  = (hi == count);
  assign status.out_free   = !out_valid || out_ready;
  assign status.emit_last  = (k_inc == count);

  // RAM control
  always_comb begin
    a_we    = (cmd.load && !full) || (cmd.merge && src_sel);
    a_waddr = cmd.load ? count[AW-1:0] : k[AW-1:0];
    a_wdata = cmd.load ? item_data.value : merge_val;
    b_we    = cmd.merge && !src_sel;
    rd_en   = cmd.run_init || cmd.run_rd2 || cmd.merge || cmd.emit_rd;
    raddr   = k[AW-1:0];
    if (cmd.run_init) begin
      raddr = lo[AW-1:0];
    end else if (cmd.run_rd2) begin
      raddr = mid[AW-1:0];
    end else if (cmd.merge) begin
      raddr = take_a ? i_inc[AW-1:0] : j_inc[AW-1:0];
    end
  end

  msb_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (a_rdata)
  );

  msb_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_scratch (
    .clk   (clk),
    .we    (b_we),
    .waddr (k[AW-1:0]),
    .wdata (merge_val),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (b_rdata)
  );

  // batch count, drop flag, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
      if (cmd.emit_ld && status.emit_last) begin
        count   <= '0;
        dropped <= 1'b0;
      end
      if (cmd.emit_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // merge pointers and heads
  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      width   <= (CW+1)'(1);
      src_sel <= 1'b0;
    end
    if (cmd.pass_init) begin
      lo <= '0;
    end
    if (cmd.run_init) begin
      mid <= mid_c;
      hi  <= hi_c;
      i   <= lo;
      j   <= mid_c;
      k   <= lo;
    end
    if (cmd.run_rd2) begin
      head_a <= $signed(rdata);
      took_a <= 1'b0;
      took_b <= 1'b1;
    end
    if (cmd.merge) begin
      head_a <= a_eff;
      head_b <= b_eff;
      took_a <= take_a;
      took_b <= !take_a;
      k      <= k_inc;
      if (take_a) begin
        i <= i_inc;
      end else begin
        j <= j_inc;
      end
      if (status.run_last) begin
        lo <= hi;
      end
    end
    if (cmd.pass_done) begin
      width   <= width << 1;
      src_sel <= !src_sel;
    end
    if (cmd.emit_init) begin
      k <= '0;
    end
    if (cmd.emit_ld) begin
      k <= k_inc;
      out_data.sorted_value <= $signed(rdata);
      out_data.last_out     <= status.emit_last;
      out_data.overflow     <= dropped;
    end
  end
endmodule
